>>> hdl/dmdt_pkg.sv
package dmdt_pkg;

    typedef logic [1:0]  mode_t;
    typedef logic [2:0]  reg_index_t;
    typedef logic [31:0] word_t;
    typedef logic [7:0]  ctrl_t;

    localparam mode_t MODE_TICK  = 2'd0;
    localparam mode_t MODE_READ  = 2'd1;
    localparam mode_t MODE_WRITE = 2'd2;

    localparam reg_index_t REG_LOAD   = 3'd0;
    localparam reg_index_t REG_VALUE  = 3'd1;
    localparam reg_index_t REG_CTRL   = 3'd2;
    localparam reg_index_t REG_INTCLR = 3'd3;
    localparam reg_index_t REG_RIS    = 3'd4;
    localparam reg_index_t REG_MIS    = 3'd5;
    localparam reg_index_t REG_BGLOAD = 3'd6;

    localparam int CTRL_ONESHOT_BIT  = 0;
    localparam int CTRL_SIZE32_BIT   = 1;
    localparam int CTRL_PRE_LSB      = 2;
    localparam int CTRL_IE_BIT       = 5;
    localparam int CTRL_PERIODIC_BIT = 6;
    localparam int CTRL_ENABLE_BIT   = 7;
    localparam int CTRL_RSVD_BIT     = 4;

    localparam ctrl_t CTRL_WRITABLE = 8'hEF;
    localparam ctrl_t CTRL_RESET    = 8'h20;

    localparam logic [1:0] PRE_DIV1  = 2'd0;
    localparam logic [1:0] PRE_DIV16 = 2'd1;

    localparam logic [7:0] PRE_END_DIV1   = 8'd0;
    localparam logic [7:0] PRE_END_DIV16  = 8'd15;
    localparam logic [7:0] PRE_END_DIV256 = 8'd255;

    localparam word_t FULL_MAX = 32'hFFFF_FFFF;
    localparam word_t HALF_MAX = 32'h0000_FFFF;

endpackage

>>> hdl/dmdt_in_if.sv
interface dmdt_in_if;
    logic                 valid;
    logic                 ready;
    dmdt_pkg::mode_t      mode;
    dmdt_pkg::reg_index_t reg_index;
    dmdt_pkg::word_t      write_data;

    modport source (output valid, output mode, output reg_index, output write_data,
                    input ready);
    modport sink (input valid, input mode, input reg_index, input write_data,
                  output ready);
endinterface

>>> hdl/dmdt_out_if.sv
interface dmdt_out_if;
    logic            valid;
    logic            ready;
    dmdt_pkg::word_t read_data;
    logic            irq;

    modport source (output valid, output read_data, output irq, input ready);
    modport sink (input valid, input read_data, input irq, output ready);
endinterface

>>> hdl/dual_mode_down_timer_core.sv
// Results are registered: in the result register, or in the skid register on a stall.
// Throughput: one item per cycle while the skid register is empty; the two-entry
// output stage (result register plus skid register) drops input ready only when full.
// Reset: rst_n is asynchronous and active low; it loads load = 0, value = all ones,
// control = 0x20, clears the raw interrupt and prescaler, and empties the output stage.
module dual_mode_down_timer_core (
    input  logic      clk,
    input  logic      rst_n,
    dmdt_in_if.sink   in_ch,
    dmdt_out_if.source out_ch
);
    import dmdt_pkg::*;

    word_t      load_reg,  load_next;
    word_t      count_reg, count_next;
    ctrl_t      ctrl_reg,  ctrl_next;
    logic       raw_reg,   raw_next;
    logic [7:0] pre_reg,   pre_next;

    word_t      out_data_reg;
    logic       out_irq_reg;
    logic       out_valid_reg;
    word_t      skid_data_reg;
    logic       skid_irq_reg;
    logic       skid_valid_reg;

    logic       accept;
    word_t      rd;
    logic       irq_res;
    word_t      size_mask;
    word_t      cnt_m;
    word_t      dec_val;
    word_t      rel_val;
    logic [7:0] pre_end;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = !skid_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.read_data = out_data_reg;
    assign out_ch.irq   = out_irq_reg;

    assign size_mask = ctrl_reg[CTRL_SIZE32_BIT] ? FULL_MAX : HALF_MAX;
    assign cnt_m     = count_reg & size_mask;
    assign dec_val   = (cnt_m - 32'd1) & size_mask;
    assign rel_val   = load_reg & size_mask;

    always_comb
    begin
        case (ctrl_reg[CTRL_PRE_LSB +: 2])
            PRE_DIV1:  pre_end = PRE_END_DIV1;
            PRE_DIV16: pre_end = PRE_END_DIV16;
            default:   pre_end = PRE_END_DIV256;
        endcase
    end

    always_comb
    begin
        load_next  = load_reg;
        count_next = count_reg;
        ctrl_next  = ctrl_reg;
        raw_next   = raw_reg;
        pre_next   = pre_reg;
        rd         = '0;
        case (in_ch.mode)
            MODE_TICK:
            begin
                if (ctrl_reg[CTRL_ENABLE_BIT])
                begin
                    if (pre_reg >= pre_end)
                    begin
                        pre_next = '0;
                        if (cnt_m != '0)
                        begin
                            count_next = dec_val;
                            if (dec_val == '0)
                            begin
                                raw_next = 1'b1;
                            end
                        end
                        else if (ctrl_reg[CTRL_ONESHOT_BIT])
                        begin
                            count_next = count_reg;
                        end
                        else if (ctrl_reg[CTRL_PERIODIC_BIT])
                        begin
                            count_next = rel_val;
                            if (rel_val == '0)
                            begin
                                raw_next = 1'b1;
                            end
                        end
                        else
                        begin
                            count_next = size_mask;
                        end
                    end
                    else
                    begin
                        pre_next = pre_reg + 8'd1;
                    end
                end
            end
            MODE_READ:
            begin
                case (in_ch.reg_index)
                    REG_LOAD:   rd = load_reg;
                    REG_VALUE:  rd = cnt_m;
                    REG_CTRL:   rd = {24'd0, ctrl_reg};
                    REG_RIS:    rd = {31'd0, raw_reg};
                    REG_MIS:    rd = {31'd0, raw_reg & ctrl_reg[CTRL_IE_BIT]};
                    REG_BGLOAD: rd = load_reg;
                    default:    rd = '0;
                endcase
            end
            MODE_WRITE:
            begin
                case (in_ch.reg_index)
                    REG_LOAD:
                    begin
                        load_next  = in_ch.write_data;
                        count_next = in_ch.write_data;
                    end
                    REG_CTRL:   ctrl_next = in_ch.write_data[7:0] & CTRL_WRITABLE;
                    REG_INTCLR: raw_next  = 1'b0;
                    REG_BGLOAD: load_next = in_ch.write_data;
                    default:    ;
                endcase
            end
            default: ;
        endcase
        irq_res = raw_next & ctrl_next[CTRL_IE_BIT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg  <= '0;
            count_reg <= FULL_MAX;
            ctrl_reg  <= CTRL_RESET;
            raw_reg   <= 1'b0;
            pre_reg   <= '0;
        end
        else if (accept)
        begin
            load_reg  <= load_next;
            count_reg <= count_next;
            ctrl_reg  <= ctrl_next;
            raw_reg   <= raw_next;
            pre_reg   <= pre_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ch.ready)
        begin
            if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ch.ready)
        begin
            if (accept)
            begin
                skid_data_reg <= rd;
                skid_irq_reg  <= irq_res;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
            out_irq_reg  <= skid_irq_reg;
        end
        else if (accept)
        begin
            out_data_reg <= rd;
            out_irq_reg  <= irq_res;
        end
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a result while the result register is empty.");

    a_intclr_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.mode == MODE_WRITE && in_ch.reg_index == REG_INTCLR) |=> !raw_reg)
        else $error("Interrupt clear did not clear the raw interrupt.");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.mode == MODE_TICK && !ctrl_reg[CTRL_ENABLE_BIT])
        |=> ($stable(count_reg) && $stable(pre_reg) && $stable(raw_reg)))
        else $error("A tick changed the counter while the timer was disabled.");

    a_rsvd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_reg[CTRL_RSVD_BIT])
        else $error("Reserved control bit is set.");
`endif

endmodule

>>> verif/dual_mode_down_timer_core_tb.sv
module dual_mode_down_timer_core_tb;
    import dmdt_pkg::*;

    localparam mode_t      MODE_NONE   = 2'd3;
    localparam reg_index_t REG_UNUSED  = 3'd7;
    localparam logic [1:0] PRE_DIV256  = 2'd2;
    localparam logic [1:0] PRE_DIV256B = 2'd3;

    localparam word_t F_ONESHOT  = word_t'(1) << CTRL_ONESHOT_BIT;
    localparam word_t F_SIZE32   = word_t'(1) << CTRL_SIZE32_BIT;
    localparam word_t F_IRQ_EN   = word_t'(1) << CTRL_IE_BIT;
    localparam word_t F_PERIODIC = word_t'(1) << CTRL_PERIODIC_BIT;
    localparam word_t F_ENABLE   = word_t'(1) << CTRL_ENABLE_BIT;

    localparam int ITEM_TARGET   = 600;
    localparam int QUIET_TAIL    = 100;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        word_t read_data;
        logic  irq;
    } timer_result_t;

    class timer_scoreboard;
        word_t         reload_val;
        word_t         count_val;
        ctrl_t         ctrl_val;
        logic          raw_int;
        logic [7:0]    presc;
        timer_result_t expected_q[$];
        int            mismatches;
        int            checked;
        int            zero_hits;
        int            reloads;
        int            wraps;

        function new();
            reload_val = '0;
            count_val  = FULL_MAX;
            ctrl_val   = CTRL_RESET;
            raw_int    = 1'b0;
            presc      = '0;
            mismatches = 0;
            checked    = 0;
            zero_hits  = 0;
            reloads    = 0;
            wraps      = 0;
        endfunction

        function word_t size_mask();
            return ctrl_val[CTRL_SIZE32_BIT] ? FULL_MAX : HALF_MAX;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_transfer(mode_t m, reg_index_t r, word_t d);
            timer_result_t res;
            logic [7:0]    pend;
            word_t         low;
            res = '0;
            case (m)
                MODE_TICK:
                    if (ctrl_val[CTRL_ENABLE_BIT]) begin
                        case (ctrl_val[CTRL_PRE_LSB +: 2])
                            PRE_DIV1:  pend = PRE_END_DIV1;
                            PRE_DIV16: pend = PRE_END_DIV16;
                            default:   pend = PRE_END_DIV256;
                        endcase
                        if (presc >= pend) begin
                            presc = '0;
                            low = count_val & size_mask();
                            if (low != 0) begin
                                count_val = (low - 32'd1) & size_mask();
                                if (count_val == 0) begin
                                    raw_int = 1'b1;
                                    zero_hits++;
                                end
                            end else if (!ctrl_val[CTRL_ONESHOT_BIT]) begin
                                if (ctrl_val[CTRL_PERIODIC_BIT]) begin
                                    count_val = reload_val & size_mask();
                                    reloads++;
                                    if (count_val == 0)
                                        raw_int = 1'b1;
                                end else begin
                                    count_val = size_mask();
                                    wraps++;
                                end
                            end
                        end else begin
                            presc = presc + 8'd1;
                        end
                    end
                MODE_READ:
                    case (r)
                        REG_LOAD, REG_BGLOAD: res.read_data = reload_val;
                        REG_VALUE:            res.read_data = count_val & size_mask();
                        REG_CTRL:             res.read_data = {24'b0, ctrl_val};
                        REG_RIS:              res.read_data = {31'b0, raw_int};
                        REG_MIS:              res.read_data = {31'b0,
                                                  raw_int & ctrl_val[CTRL_IE_BIT]};
                        default:              res.read_data = '0;
                    endcase
                MODE_WRITE:
                    case (r)
                        REG_LOAD:
                        begin
                            reload_val = d;
                            count_val  = d;
                        end
                        REG_CTRL:   ctrl_val   = d[7:0] & CTRL_WRITABLE;
                        REG_INTCLR: raw_int    = 1'b0;
                        REG_BGLOAD: reload_val = d;
                        default:    ;
                    endcase
                default: ;
            endcase
            res.irq = raw_int & ctrl_val[CTRL_IE_BIT];
            expected_q.push_back(res);
        endfunction

        function void check_result(word_t rd, logic irq);
            timer_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: read_data=%h irq=%b",
                             $time, rd, irq);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (rd !== want.read_data || irq !== want.irq) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected read_data=%h irq=%b, actual read_data=%h irq=%b",
                             $time, want.read_data, want.irq, rd, irq);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   items_sent;
    int   tick_items;
    int   read_items;
    int   write_items;
    int   other_items;
    int   quiet_cycles;
    int   stall_left;

    timer_scoreboard sb = new();

    dmdt_in_if  in_if ();
    dmdt_out_if out_if ();

    dual_mode_down_timer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic word_t pick_value();
        if ($urandom_range(0, 4) != 0)
            return word_t'($urandom_range(0, 40));
        return $urandom;
    endfunction

    function automatic word_t rand_ctrl();
        word_t c;
        int    r;
        c = $urandom;
        c[CTRL_ENABLE_BIT] = ($urandom_range(0, 4) != 0);
        r = $urandom_range(0, 15);
        if (r < 10)
            c[CTRL_PRE_LSB +: 2] = PRE_DIV1;
        else if (r < 14)
            c[CTRL_PRE_LSB +: 2] = PRE_DIV16;
        else if (r == 14)
            c[CTRL_PRE_LSB +: 2] = PRE_DIV256;
        else
            c[CTRL_PRE_LSB +: 2] = PRE_DIV256B;
        return c;
    endfunction

    task automatic send_item(input mode_t m, input reg_index_t r, input word_t d);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.mode       <= m;
        in_if.reg_index  <= r;
        in_if.write_data <= d;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_transfer(m, r, d);
        case (m)
            MODE_TICK:  tick_items++;
            MODE_READ:  read_items++;
            MODE_WRITE: write_items++;
            default:    other_items++;
        endcase
        if (m != MODE_NONE)
            items_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        out_if.ready = 1'b0;
        stall_left   = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.read_data, out_if.irq);
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        word_t      ctrl_word;
        int         phase_len;
        int         pick;
        int         tick_share;
        bit         pressure_done;
        reg_index_t ri;

        rst_n            = 1'b0;
        idle_on          = 1'b1;
        items_sent       = 0;
        tick_items       = 0;
        read_items       = 0;
        write_items      = 0;
        other_items      = 0;
        pressure_done    = 1'b0;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_TICK;
        in_if.reg_index  = REG_LOAD;
        in_if.write_data = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < 8; i++)
            send_item(MODE_READ, reg_index_t'(i), FULL_MAX);
        send_item(MODE_TICK, REG_LOAD, '0);
        send_item(MODE_WRITE, REG_CTRL, FULL_MAX);
        send_item(MODE_READ, REG_CTRL, '0);
        send_item(MODE_WRITE, REG_CTRL, F_ENABLE | F_PERIODIC | F_IRQ_EN | F_SIZE32);
        send_item(MODE_WRITE, REG_LOAD, 32'd2);
        repeat (3) send_item(MODE_TICK, REG_LOAD, '0);
        send_item(MODE_WRITE, REG_INTCLR, FULL_MAX);
        send_item(MODE_WRITE, REG_BGLOAD, '0);
        repeat (3) send_item(MODE_TICK, REG_LOAD, '0);
        send_item(MODE_WRITE, REG_CTRL, F_ENABLE | F_IRQ_EN | F_ONESHOT);
        send_item(MODE_WRITE, REG_LOAD, 32'hFFFF_0001);
        repeat (2) send_item(MODE_TICK, REG_LOAD, '0);
        send_item(MODE_WRITE, REG_CTRL, F_ENABLE);
        send_item(MODE_TICK, REG_LOAD, '0);
        send_item(MODE_READ, REG_MIS, '0);
        send_item(MODE_WRITE, REG_VALUE, FULL_MAX);
        send_item(MODE_WRITE, REG_UNUSED, FULL_MAX);
        send_item(MODE_NONE, REG_UNUSED, FULL_MAX);
        send_item(MODE_READ, REG_VALUE, '0);

        while (items_sent < ITEM_TARGET) begin
            idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (!pressure_done && items_sent > ITEM_TARGET / 2) begin
                in_if.valid <= 1'b0;
                do
                    @(negedge clk);
                while (sb.pending() != 0);
                pressure_done = 1'b1;
            end
            ctrl_word = rand_ctrl();
            send_item(MODE_WRITE, REG_CTRL, ctrl_word);
            send_item(MODE_WRITE, $urandom_range(0, 3) != 0 ? REG_LOAD : REG_BGLOAD,
                      pick_value());
            if (ctrl_word[CTRL_PRE_LSB + 1]) begin
                phase_len  = 270;
                tick_share = 97;
            end else begin
                phase_len  = $urandom_range(10, 40);
                tick_share = 65;
            end
            repeat (phase_len) begin
                if (items_sent >= ITEM_TARGET - QUIET_TAIL)
                begin
                    idle_on = 1'b0;
                end
                if (items_sent < ITEM_TARGET)
                begin
                    pick = $urandom_range(0, 99);
                    ri   = reg_index_t'($urandom_range(0, 7));
                    if (pick < tick_share)
                        send_item(MODE_TICK, ri, $urandom);
                    else if (pick < tick_share + (100 - tick_share) * 4 / 9)
                        send_item(MODE_READ, ri, $urandom);
                    else if (pick < 92)
                        send_item(MODE_WRITE, ri, ri == REG_CTRL ? rand_ctrl() : pick_value());
                    else if (pick < 97)
                        send_item(MODE_WRITE, REG_INTCLR, $urandom);
                    else
                        send_item(MODE_NONE, ri, $urandom);
                end
            end
        end

        idle_on = 1'b0;
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d ticks, %0d reads, %0d writes, %0d unused-mode items; %0d checked.",
                 tick_items, read_items, write_items, other_items, sb.checked);
        $display("Counter reached zero %0d times, reloaded %0d times and wrapped %0d times.",
                 sb.zero_hits, sb.reloads, sb.wraps);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
